/* hw/rtl/hsfr_pkg.sv */
package hsfr_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_READY  = 3'd1,
        ST_WRITE_FAIL = 3'd2,
        ST_READ_FAIL  = 3'd3,
        ST_TEMP_CRC   = 3'd4,
        ST_HUM_CRC    = 3'd5,
        ST_PENDING    = 3'd6
    } t_status;

    // Configuration register indexes.
    localparam logic REG_SENSOR_READY = 1'b0;
    localparam logic REG_MEASURE_WAIT = 1'b1;

    localparam logic [7:0]  WAIT_RESET = 8'd15;
    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;

    // Scale factors for round(full_scale * raw / 65535), written as
    // floor((raw * 2 * full_scale + 65535) / 131070).
    localparam logic [15:0] TEMP_SCALE = 16'd35000;
    localparam logic [15:0] HUM_SCALE  = 16'd20000;
    localparam logic [31:0] ROUND_BIAS = 32'd65535;
    localparam logic [16:0] WORD_MAX   = 17'd65535;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // Control information that travels down the pipeline with each request.
    typedef struct packed {
        logic        issue;
        t_status     status;
        logic [31:0] ts;
    } t_ctl;

    // One byte of the CRC-8, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int j = 0; j < 8; j++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/hsfr_lane.sv */
module hsfr_lane (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_adv,
    input  logic [15:0] i_raw,
    input  logic [7:0]  i_crc,
    input  logic [15:0] i_scale,
    output logic        o_crc_ok,
    output logic [14:0] o_quot
);
    import hsfr_pkg::*;

    logic [31:0] r_prod;
    logic [14:0] r_quot;
    logic [30:0] half;
    logic [14:0] q0;
    logic [16:0] rem;
    logic [14:0] n_quot;

    assign o_crc_ok = (crc8_byte(crc8_byte(CRC_INIT, i_raw[15:8]), i_raw[7:0]) == i_crc);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= ({16'b0, i_raw} * {16'b0, i_scale}) + ROUND_BIAS;
        end
    end

    // Divide by 131070: halve, then divide by 65535 using 2^16 = 65535 + 1.
    // The remainder estimate stays below twice the divisor, so one correction suffices.
    always_comb begin
        half   = r_prod[31:1];
        q0     = half[30:16];
        rem    = {1'b0, half[15:0]} + {2'b0, q0};
        n_quot = (rem >= WORD_MAX) ? (q0 + 15'd1) : q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

/* hw/rtl/hsfr_ctrl.sv */
module hsfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic              i_load,
    input  logic [31:0]       i_now_ms,
    input  logic              i_write_ok,
    input  logic              i_fetch_ok,
    input  logic              i_t_crc_ok,
    input  logic              i_h_crc_ok,
    output hsfr_pkg::t_ctl    o_ctl
);
    import hsfr_pkg::*;

    // The reader is either idle or waiting for a measurement to become due.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } t_phase;

    logic        r_sensor_ready;
    logic [7:0]  r_wait_ms;
    t_phase      r_phase;
    logic [31:0] r_ready_time;
    t_ctl        r_ctl;

    t_phase      n_phase;
    logic [31:0] n_ready_time;
    logic [31:0] diff;
    t_ctl        n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_ready <= 1'b0;
            r_wait_ms      <= WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SENSOR_READY: r_sensor_ready <= i_cfg_data[0];
                REG_MEASURE_WAIT: r_wait_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        diff         = i_now_ms - r_ready_time;
        n_phase      = r_phase;
        n_ready_time = r_ready_time;
        n_ctl.issue  = 1'b0;
        n_ctl.status = ST_PENDING;
        n_ctl.ts     = i_now_ms;
        if (!r_sensor_ready) begin
            n_ctl.status = ST_NOT_READY;
        end else if (r_phase == S_IDLE) begin
            n_ctl.issue = 1'b1;
            if (!i_write_ok) begin
                n_ctl.status = ST_WRITE_FAIL;
            end else begin
                n_ready_time = i_now_ms + {24'b0, r_wait_ms};
                n_phase      = S_WAIT;
            end
        end else if (diff[31]) begin
            n_ctl.status = ST_PENDING;
        end else begin
            n_phase = S_IDLE;
            if (!i_fetch_ok) begin
                n_ctl.status = ST_READ_FAIL;
            end else if (!i_t_crc_ok) begin
                n_ctl.status = ST_TEMP_CRC;
            end else if (!i_h_crc_ok) begin
                n_ctl.status = ST_HUM_CRC;
            end else begin
                n_ctl.status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= S_IDLE;
            r_ready_time <= 32'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_ready_time <= n_ready_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;

endmodule

/* hw/rtl/hsfr_merge.sv */
module hsfr_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hsfr_pkg::t_ctl    i_ctl,
    input  logic [14:0]       i_t_quot,
    input  logic [14:0]       i_h_quot,
    output logic              o_valid,
    output logic              o_issue_measure,
    output logic [14:0]       o_temperature_centi,
    output logic [13:0]       o_humidity_centi,
    output logic              o_reading_valid,
    output logic [2:0]        o_status,
    output logic [31:0]       o_timestamp_ms
);
    import hsfr_pkg::*;

    logic        r_out_v;
    logic        r_last_v;
    logic [14:0] r_last_t;
    logic [13:0] r_last_h;
    logic        r_issue;
    logic [14:0] r_temp;
    logic [13:0] r_hum;
    logic        r_rvalid;
    logic [2:0]  r_status;
    logic [31:0] r_ts;

    logic        good;
    logic [14:0] n_temp;
    logic [13:0] n_hum;
    logic        n_rvalid;

    always_comb begin
        good     = (i_ctl.status == ST_OK);
        n_temp   = good ? (i_t_quot - TEMP_OFFSET) : r_last_t;
        n_hum    = good ? i_h_quot[13:0] : r_last_h;
        n_rvalid = good || ((i_ctl.status == ST_PENDING) && r_last_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_last_v <= 1'b0;
            r_last_t <= 15'd0;
            r_last_h <= 14'd0;
        end else if (i_en) begin
            r_out_v <= i_valid;
            if (i_valid && good) begin
                r_last_v <= 1'b1;
                r_last_t <= n_temp;
                r_last_h <= n_hum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_issue  <= i_ctl.issue;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_rvalid <= n_rvalid;
            r_status <= i_ctl.status;
            r_ts     <= i_ctl.ts;
        end
    end

    assign o_valid             = r_out_v;
    assign o_issue_measure     = r_issue;
    assign o_temperature_centi = r_temp;
    assign o_humidity_centi    = r_hum;
    assign o_reading_valid     = r_rvalid;
    assign o_status            = r_status;
    assign o_timestamp_ms      = r_ts;

endmodule

/* hw/rtl/humidity_sensor_frame_reader_top.sv */
// Channel   Direction  Handshake             Carries
// poll      in         i_valid / o_stall     now_ms, write_ok, fetch_ok, six frame bytes
// result    out        o_valid / i_stall     issue flag, temperature, humidity, valid, status, time
// config    in         i_cfg_valid / o_cfg_ready  register index and write data
//
// One poll request is taken every cycle while o_stall is low. The measurement state is updated
// in the cycle a poll is accepted; the two conversion lanes each register the constant multiplier
// product and then the divide-by-131070 quotient, and the merge stage registers the result.
// Reset (synchronous, active low) empties the pipeline and restores register defaults.
// A stall on the result side backs up only as far as there are full stages before it.
module humidity_sensor_frame_reader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_now_ms,
    input  logic        i_write_ok,
    input  logic        i_fetch_ok,
    input  logic [47:0] i_frame,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_issue_measure,
    output logic [14:0] o_temperature_centi,
    output logic [13:0] o_humidity_centi,
    output logic        o_reading_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_timestamp_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import hsfr_pkg::*;

    // Stage occupancy flags for the lane stages.
    logic r_v1;
    logic r_v2;
    t_ctl r_ctl2;

    logic en_out;
    logic en2;
    logic en1;
    logic accept;
    logic t_crc_ok;
    logic h_crc_ok;
    logic [14:0] t_quot;
    logic [14:0] h_quot;
    t_ctl ctl1;

    // Each stage moves on when the stage after it is empty or moving.
    assign en_out  = !o_valid || !i_stall;
    assign en2     = !r_v2 || en_out;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept  = i_valid && en1;

    // Configuration is always accepted; the user must write it only while the block is quiet, unenforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ctl2 <= ctl1;
        end
    end

    // Temperature lane: bytes one and two, CRC in byte three.
    hsfr_lane u_lane_t (
        .i_clk    (i_clk),
        .i_load   (en1),
        .i_adv    (en2),
        .i_raw    (i_frame[47:32]),
        .i_crc    (i_frame[31:24]),
        .i_scale  (TEMP_SCALE),
        .o_crc_ok (t_crc_ok),
        .o_quot   (t_quot)
    );

    // Humidity lane: bytes four and five, CRC in byte six.
    hsfr_lane u_lane_h (
        .i_clk    (i_clk),
        .i_load   (en1),
        .i_adv    (en2),
        .i_raw    (i_frame[23:8]),
        .i_crc    (i_frame[7:0]),
        .i_scale  (HUM_SCALE),
        .o_crc_ok (h_crc_ok),
        .o_quot   (h_quot)
    );

    hsfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_load      (en1),
        .i_now_ms    (i_now_ms),
        .i_write_ok  (i_write_ok),
        .i_fetch_ok  (i_fetch_ok),
        .i_t_crc_ok  (t_crc_ok),
        .i_h_crc_ok  (h_crc_ok),
        .o_ctl       (ctl1)
    );

    // The merge stage holds the last good reading for results without a new one; results leave in poll order.
    hsfr_merge u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (en_out),
        .i_valid             (r_v2),
        .i_ctl               (r_ctl2),
        .i_t_quot            (t_quot),
        .i_h_quot            (h_quot),
        .o_valid             (o_valid),
        .o_issue_measure     (o_issue_measure),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_reading_valid     (o_reading_valid),
        .o_status            (o_status),
        .o_timestamp_ms      (o_timestamp_ms)
    );

`ifndef ASSERT_OFF
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted request did not enter the first stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en2) |=> r_v1)
        else $error("blocked first stage lost its request");

    a_issue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_issue_measure) |->
        (o_status == ST_WRITE_FAIL || o_status == ST_PENDING))
        else $error("measurement issued with an unexpected status");

    a_ok_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_reading_valid && !o_issue_measure))
        else $error("successful reading not flagged valid");
`endif

endmodule
